FILE: rtl/gld_pkg.sv
package gld_pkg;

  localparam int TableEntries = 4096;
  localparam int MaxCodeBits = 12;
  localparam int StackDepth = 4096;
  localparam int CodeW = 13;
  localparam int TabAw = 12;
  localparam int StkAw = 12;
  localparam int SpW = 13;

  localparam logic [1:0] ACT_SUPPLY = 2'd0;
  localparam logic [1:0] ACT_PULL = 2'd1;
  localparam logic [1:0] ACT_START = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  localparam logic [2:0] ST_PIXEL = 3'd0;
  localparam logic [2:0] ST_NEED = 3'd1;
  localparam logic [2:0] ST_END = 3'd2;
  localparam logic [2:0] ST_EXHAUSTED = 3'd3;
  localparam logic [2:0] ST_CORRUPT = 3'd4;
  localparam logic [2:0] ST_FULL = 3'd5;

  localparam logic [1:0] PH_FRESH = 2'd0;
  localparam logic [1:0] PH_RUN = 2'd1;
  localparam logic [1:0] PH_END = 2'd2;
  localparam logic [1:0] PH_BAD = 2'd3;

  localparam logic [1:0] CMD_SUPPLY = 2'd0;
  localparam logic [1:0] CMD_PULL = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic [3:0] REG_MIN_CODE_SIZE = 4'd0;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] data_byte;
    logic [3:0] size;
  } cmd_t;

  localparam int QDepth = 2;
  localparam int QAw = 1;

endpackage

FILE: rtl/gld_if.sv
interface gld_in_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  modport source(output valid, output action, output data_byte, input ready);
  modport sink(input valid, input action, input data_byte, output ready);
endinterface

interface gld_out_if;
  logic valid;
  logic ready;
  logic [7:0] pixel_index;
  logic [2:0] status;
  modport source(output valid, output pixel_index, output status, input ready);
  modport sink(input valid, input pixel_index, input status, output ready);
endinterface

FILE: rtl/gif_lzw_decoder.sv
// channel | dir | payload
// in      | in  | action[1:0], data_byte[7:0]
// out     | out | pixel_index[7:0], status[2:0]
// cfg     | apb | min_code_size at 0x0
// Supply/start: handled in S_IDLE. Pull from a filled stack: S_PREAD (stack
// memory read), then S_POP. Pull that decodes: S_CODE, where status-only results
// and root codes after clear end; else S_WALK and S_WREAD per table entry walked,
// then S_PREAD, S_POP. Table/stack reads are registered. Reset is synchronous;
// a two-entry queue lets input flow while the back end or output stalls.
module gif_lzw_decoder (
  input  logic clk,
  input  logic rst,
  gld_in_if.sink in_ch,
  gld_out_if.source out_ch,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  logic [3:0] min_code_size;
  logic q_valid;
  logic q_ready;
  gld_pkg::cmd_t q_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {28'd0, min_code_size} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_code_size <= 4'd8;
    end else if (psel && penable && pwrite
                 && paddr == 2'(gld_pkg::REG_MIN_CODE_SIZE)) begin
      min_code_size <= pwdata[3:0];
    end
  end

  gld_front u_front (
    .clk(clk), .rst(rst),
    .action(in_ch.action), .data_byte(in_ch.data_byte),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .min_code_size(min_code_size),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd)
  );

  gld_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_cmd(q_cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .pixel_index(out_ch.pixel_index), .status(out_ch.status)
  );
endmodule

FILE: rtl/gld_front.sv
module gld_front (
  input  logic clk,
  input  logic rst,
  input  logic [1:0] action,
  input  logic [7:0] data_byte,
  input  logic in_valid,
  output logic in_ready,
  input  logic [3:0] min_code_size,
  output logic q_valid,
  input  logic q_ready,
  output gld_pkg::cmd_t q_cmd
);
  gld_pkg::cmd_t mem [gld_pkg::QDepth];
  logic [gld_pkg::QAw-1:0] wr_ptr;
  logic [gld_pkg::QAw-1:0] rd_ptr;
  logic [gld_pkg::QAw:0] fill;
  logic push_en;
  logic pop_en;
  logic [3:0] sat_size;

  always_comb begin
    sat_size = min_code_size;
    if (min_code_size < 4'd2) sat_size = 4'd2;
    if (min_code_size > 4'd8) sat_size = 4'd8;
  end

  assign in_ready = (fill != (gld_pkg::QAw+1)'(gld_pkg::QDepth));
  assign push_en = in_valid && in_ready && (action != gld_pkg::ACT_NONE);
  assign q_valid = (fill != '0);
  assign pop_en = q_valid && q_ready;
  assign q_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[wr_ptr].cmd <= action;
      mem[wr_ptr].data_byte <= data_byte;
      mem[wr_ptr].size <= sat_size;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push_en) wr_ptr <= wr_ptr + 1'b1;
      if (pop_en) rd_ptr <= rd_ptr + 1'b1;
      fill <= fill + (gld_pkg::QAw+1)'(push_en) - (gld_pkg::QAw+1)'(pop_en);
    end
  end
endmodule

FILE: rtl/gld_back.sv
module gld_back (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  output logic q_ready,
  input  gld_pkg::cmd_t q_cmd,
  output logic out_valid,
  input  logic out_ready,
  output logic [7:0] pixel_index,
  output logic [2:0] status
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CODE  = 6'b000010,
    S_WALK  = 6'b000100,
    S_WREAD = 6'b001000,
    S_POP   = 6'b010000,
    S_PREAD = 6'b100000
  } state_t;

  state_t state;
  logic [11:0] prefix_mem [gld_pkg::TableEntries];
  logic [7:0] suffix_mem [gld_pkg::TableEntries];
  logic [7:0] stack_mem [gld_pkg::StackDepth];

  logic [3:0] active_size;
  logic [31:0] bit_buffer;
  logic [5:0] bit_count;
  logic [7:0] block_remaining;
  logic data_done;
  logic [gld_pkg::SpW-1:0] stack_pointer;
  logic [3:0] code_width;
  logic [gld_pkg::CodeW-1:0] next_code;
  logic [gld_pkg::CodeW-1:0] width_limit;
  logic [7:0] first_char;
  logic [11:0] previous_code;
  logic [1:0] phase;
  logic [11:0] cur_code;
  logic [11:0] in_code;
  logic [11:0] pref_rd;
  logic [7:0] suf_rd;
  logic [7:0] stk_rd;

  logic [gld_pkg::CodeW-1:0] clr;
  logic [11:0] code_mask;
  logic [11:0] new_code;
  logic [gld_pkg::CodeW-1:0] nc_inc;

  logic stk_we;
  logic [gld_pkg::StkAw-1:0] stk_wa;
  logic [7:0] stk_wd;
  logic [gld_pkg::TabAw-1:0] tab_ra;
  logic [gld_pkg::StkAw-1:0] stk_ra;

  assign clr = gld_pkg::CodeW'(1) << active_size;
  assign code_mask = 12'((13'(1) << code_width) - 13'd1);
  assign new_code = bit_buffer[11:0] & code_mask;
  assign nc_inc = next_code + 1'b1;
  assign q_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[stk_wa] <= stk_wd;
    stk_rd <= stack_mem[stk_ra];
    pref_rd <= prefix_mem[tab_ra];
    suf_rd <= suffix_mem[tab_ra];
  end

  always_comb begin
    stk_we = 1'b0;
    stk_wa = stack_pointer[gld_pkg::StkAw-1:0];
    stk_wd = first_char;
    tab_ra = cur_code;
    stk_ra = 12'(stack_pointer - 1'b1);
    if (state == S_WALK) begin
      tab_ra = cur_code;
    end
    if (state == S_WREAD) begin
      stk_we = (stack_pointer < gld_pkg::SpW'(gld_pkg::StackDepth));
      stk_wd = (13'(cur_code) >= clr) ? suf_rd : cur_code[7:0];
    end
    if (state == S_CODE) begin
      stk_we = (new_code == 12'(next_code)) && (phase == gld_pkg::PH_RUN)
               && (bit_count >= 6'(code_width)) && (13'(new_code) > clr + 1'b1);
      stk_wd = first_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      pixel_index <= '0;
      status <= '0;
      active_size <= 4'd8;
      bit_buffer <= '0;
      bit_count <= '0;
      block_remaining <= '0;
      data_done <= 1'b0;
      stack_pointer <= '0;
      code_width <= 4'd9;
      next_code <= 13'd258;
      width_limit <= 13'd512;
      first_char <= '0;
      previous_code <= '0;
      phase <= gld_pkg::PH_FRESH;
      cur_code <= '0;
      in_code <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid && !out_valid) begin
            case (q_cmd.cmd)
              gld_pkg::CMD_START: begin
                active_size <= q_cmd.size;
                bit_buffer <= '0;
                bit_count <= '0;
                block_remaining <= '0;
                data_done <= 1'b0;
                first_char <= '0;
                previous_code <= '0;
                code_width <= q_cmd.size + 4'd1;
                next_code <= (gld_pkg::CodeW'(1) << q_cmd.size) + 13'd2;
                width_limit <= gld_pkg::CodeW'(2) << q_cmd.size;
                stack_pointer <= '0;
                phase <= gld_pkg::PH_FRESH;
              end
              gld_pkg::CMD_SUPPLY: begin
                if (!data_done && phase != gld_pkg::PH_END) begin
                  if (block_remaining == 8'd0) begin
                    if (q_cmd.data_byte == 8'd0) data_done <= 1'b1;
                    else block_remaining <= q_cmd.data_byte;
                  end else if (bit_count > 6'd24) begin
                    out_valid <= 1'b1;
                    pixel_index <= '0;
                    status <= gld_pkg::ST_FULL;
                  end else begin
                    bit_buffer <= bit_buffer | (32'(q_cmd.data_byte) << bit_count);
                    bit_count <= bit_count + 6'd8;
                    block_remaining <= block_remaining - 8'd1;
                  end
                end
              end
              default: begin
                if (phase == gld_pkg::PH_END) begin
                  out_valid <= 1'b1;
                  pixel_index <= '0;
                  status <= gld_pkg::ST_END;
                end else if (phase == gld_pkg::PH_BAD) begin
                  out_valid <= 1'b1;
                  pixel_index <= '0;
                  status <= gld_pkg::ST_CORRUPT;
                end else if (stack_pointer != '0) begin
                  state <= S_PREAD;
                end else begin
                  state <= S_CODE;
                end
              end
            endcase
          end
        end
        S_PREAD: begin
          state <= S_POP;
        end
        S_POP: begin
          stack_pointer <= stack_pointer - 1'b1;
          out_valid <= 1'b1;
          pixel_index <= stk_rd;
          status <= gld_pkg::ST_PIXEL;
          state <= S_IDLE;
        end
        S_CODE: begin
          if (bit_count < 6'(code_width)) begin
            out_valid <= 1'b1;
            pixel_index <= '0;
            status <= data_done ? gld_pkg::ST_EXHAUSTED : gld_pkg::ST_NEED;
            state <= S_IDLE;
          end else begin
            bit_buffer <= bit_buffer >> code_width;
            bit_count <= bit_count - 6'(code_width);
            if (13'(new_code) == clr) begin
              code_width <= active_size + 4'd1;
              next_code <= clr + 13'd2;
              width_limit <= clr << 1;
              stack_pointer <= '0;
              phase <= gld_pkg::PH_FRESH;
            end else if (13'(new_code) == clr + 13'd1) begin
              phase <= gld_pkg::PH_END;
              out_valid <= 1'b1;
              pixel_index <= '0;
              status <= gld_pkg::ST_END;
              state <= S_IDLE;
            end else if (phase == gld_pkg::PH_FRESH) begin
              state <= S_IDLE;
              out_valid <= 1'b1;
              if (13'(new_code) > clr) begin
                phase <= gld_pkg::PH_BAD;
                pixel_index <= '0;
                status <= gld_pkg::ST_CORRUPT;
              end else begin
                first_char <= new_code[7:0];
                previous_code <= new_code;
                phase <= gld_pkg::PH_RUN;
                pixel_index <= new_code[7:0];
                status <= gld_pkg::ST_PIXEL;
              end
            end else if (13'(new_code) > next_code) begin
              phase <= gld_pkg::PH_BAD;
              out_valid <= 1'b1;
              pixel_index <= '0;
              status <= gld_pkg::ST_CORRUPT;
              state <= S_IDLE;
            end else begin
              in_code <= new_code;
              if (13'(new_code) == next_code) begin
                if (stack_pointer >= gld_pkg::SpW'(gld_pkg::StackDepth)) begin
                  phase <= gld_pkg::PH_BAD;
                  out_valid <= 1'b1;
                  pixel_index <= '0;
                  status <= gld_pkg::ST_CORRUPT;
                  state <= S_IDLE;
                end else begin
                  stack_pointer <= stack_pointer + 1'b1;
                  cur_code <= previous_code;
                  state <= S_WALK;
                end
              end else begin
                cur_code <= new_code;
                state <= S_WALK;
              end
            end
          end
        end
        S_WALK: begin
          state <= S_WREAD;
        end
        S_WREAD: begin
          if (stack_pointer >= gld_pkg::SpW'(gld_pkg::StackDepth)) begin
            phase <= gld_pkg::PH_BAD;
            out_valid <= 1'b1;
            pixel_index <= '0;
            status <= gld_pkg::ST_CORRUPT;
            state <= S_IDLE;
          end else if (13'(cur_code) >= clr) begin
            stack_pointer <= stack_pointer + 1'b1;
            if (pref_rd >= cur_code) begin
              phase <= gld_pkg::PH_BAD;
              out_valid <= 1'b1;
              pixel_index <= '0;
              status <= gld_pkg::ST_CORRUPT;
              state <= S_IDLE;
            end else begin
              cur_code <= pref_rd;
              state <= S_WALK;
            end
          end else begin
            first_char <= cur_code[7:0];
            stack_pointer <= stack_pointer + 1'b1;
            if (next_code < gld_pkg::CodeW'(gld_pkg::TableEntries)) begin
              next_code <= nc_inc;
              if (nc_inc >= width_limit && code_width < 4'(gld_pkg::MaxCodeBits)) begin
                width_limit <= width_limit << 1;
                code_width <= code_width + 4'd1;
              end
            end
            previous_code <= in_code;
            state <= S_PREAD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_WREAD && !(stack_pointer >= gld_pkg::SpW'(gld_pkg::StackDepth))
        && !(13'(cur_code) >= clr) && next_code < gld_pkg::CodeW'(gld_pkg::TableEntries)) begin
      prefix_mem[next_code[gld_pkg::TabAw-1:0]] <= previous_code;
      suffix_mem[next_code[gld_pkg::TabAw-1:0]] <= cur_code[7:0];
    end
  end
endmodule
